FILE: sv/tcgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

    // Console geometry
    localparam int PANEL_GATES   = 528;
    localparam int PANEL_SOURCES = 792;
    localparam int PIXEL_SCALE   = 2;
    localparam int TEXT_COLUMNS  = 32;
    localparam int TEXT_LINES    = 24;
    localparam int GLYPH_COUNT   = 95;

    localparam int GLYPH_WIDTH   = 8;
    localparam int GLYPH_HEIGHT  = 16;
    localparam int MARGIN_GATE   = 8;
    localparam int MARGIN_SOURCE = 12;
    localparam int FIRST_CODE    = 32;
    localparam int LAST_CODE     = FIRST_CODE + GLYPH_COUNT - 1;
    localparam int FALLBACK_CODE = 63;   // '?'
    localparam int CELL_W        = GLYPH_WIDTH * PIXEL_SCALE;
    localparam int CELL_H        = GLYPH_HEIGHT * PIXEL_SCALE;

    // '?' may itself lie outside the glyph set; then the cell stays blank
    localparam bit FALLBACK_OK = (FALLBACK_CODE >= FIRST_CODE) && (FALLBACK_CODE <= LAST_CODE);

    // Field widths
    localparam int CMD_W   = 3;
    localparam int CODE_W  = 8;
    localparam int GIDX_W  = 7;
    localparam int GROW_W  = 4;
    localparam int BITS_W  = 8;
    localparam int GATE_W  = 10;
    localparam int BIDX_W  = 7;
    localparam int PIX_W   = 8;

    localparam int PIX_IDX_W   = $clog2(PIX_W);
    localparam int SY_W        = BIDX_W + PIX_IDX_W;
    localparam int LINE_CNT_W  = $clog2(TEXT_LINES + 1);
    localparam int SLOT_W      = (TEXT_LINES > 1) ? $clog2(TEXT_LINES) : 1;
    localparam int COL_W       = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;
    localparam int LEN_W       = $clog2(TEXT_COLUMNS + 1);
    localparam int TEXT_DEPTH  = TEXT_LINES * TEXT_COLUMNS;
    localparam int TADDR_W     = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int GLYPH_IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int FROW_W      = $clog2(GLYPH_HEIGHT);
    localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int FADDR_W     = $clog2(FONT_DEPTH);
    localparam int STEP_W      = PIX_IDX_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_FONT = 3'd0,
        CMD_PUT_CHAR  = 3'd1,
        CMD_END_LINE  = 3'd2,
        CMD_READ      = 3'd3,
        CMD_CLEAR     = 3'd4
    } t_cmd;

    typedef logic [TEXT_LINES-1:0][LEN_W-1:0] t_len_arr;

    // Snapshot of the held lines that the renderer looks at
    typedef struct packed {
        logic [SLOT_W-1:0]     oldest;
        logic [LINE_CNT_W-1:0] held;
        t_len_arr              lengths;
    } t_console;

    // Per-pixel lookup request out of the address unit
    typedef struct packed {
        logic              hit;
        logic [FROW_W-1:0] row;
        logic [TADDR_W-1:0] text_addr;
    } t_pix_req;

endpackage

`default_nettype wire

FILE: sv/text_console_glyph_renderer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Read byte: result strobed on o_valid once the text/font lookup chain is through;
// busy until the result is strobed, so only one read is in flight at a time.
// End line: busy while the pending characters, if any, are copied into text memory.
// Load font, put char, clear, unknown codes: done at the transfer, never busy.
// Reset is synchronous: console and pending line empty, font memory kept.
// Results are single-cycle strobes; the receiver cannot stall.
module text_console_glyph_renderer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [tcgr_pkg::CMD_W-1:0]    i_command,
    input  wire logic [tcgr_pkg::CODE_W-1:0]   i_char_code,
    input  wire logic [tcgr_pkg::GIDX_W-1:0]   i_glyph_index,
    input  wire logic [tcgr_pkg::GROW_W-1:0]   i_glyph_row,
    input  wire logic [tcgr_pkg::BITS_W-1:0]   i_glyph_bits,
    input  wire logic [tcgr_pkg::GATE_W-1:0]   i_gate_row,
    input  wire logic [tcgr_pkg::BIDX_W-1:0]   i_byte_index,
    output logic                               o_valid,
    output logic      [tcgr_pkg::PIX_W-1:0]    o_pixel_byte
);

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } t_state;

    t_state                               r_state;
    logic [tcgr_pkg::SLOT_W-1:0]          r_oldest;
    logic [tcgr_pkg::LINE_CNT_W-1:0]      r_held;
    tcgr_pkg::t_len_arr                   r_len;
    logic [tcgr_pkg::CODE_W-1:0]          r_pend [tcgr_pkg::TEXT_COLUMNS];
    logic [tcgr_pkg::LEN_W-1:0]           r_count;
    logic                                 r_stopped;
    logic [tcgr_pkg::SLOT_W-1:0]          r_copy_slot;
    logic [tcgr_pkg::COL_W-1:0]           r_copy_idx;
    logic [tcgr_pkg::COL_W-1:0]           r_copy_last;

    logic                                 w_accept;
    logic                                 w_render_busy;
    logic                                 w_full;
    logic [tcgr_pkg::SLOT_W-1:0]          w_oldest_inc;
    logic [tcgr_pkg::SLOT_W-1:0]          w_commit_slot;
    logic                                 w_font_we;
    logic [tcgr_pkg::FADDR_W-1:0]         w_font_waddr;
    logic [tcgr_pkg::FADDR_W-1:0]         w_font_raddr;
    logic [tcgr_pkg::BITS_W-1:0]          w_font_rdata;
    logic                                 w_text_we;
    logic [tcgr_pkg::TADDR_W-1:0]         w_text_waddr;
    logic [tcgr_pkg::TADDR_W-1:0]         w_text_raddr;
    logic [tcgr_pkg::CODE_W-1:0]          w_text_rdata;
    tcgr_pkg::t_console                   w_con;

    assign busy     = (r_state != ST_IDLE) || w_render_busy;
    assign w_accept = start && !busy;

    // Slot that the committed line lands in; a full console drops its oldest line
    always_comb begin
        logic [tcgr_pkg::SLOT_W:0] sum;

        w_full = r_held >= tcgr_pkg::LINE_CNT_W'(tcgr_pkg::TEXT_LINES);
        if (r_oldest == tcgr_pkg::SLOT_W'(tcgr_pkg::TEXT_LINES - 1)) begin
            w_oldest_inc = '0;
        end else begin
            w_oldest_inc = r_oldest + 1'b1;
        end
        sum = (tcgr_pkg::SLOT_W+1)'(r_oldest) + (tcgr_pkg::SLOT_W+1)'(r_held);
        if (w_full) begin
            w_commit_slot = r_oldest;
        end else if (sum >= (tcgr_pkg::SLOT_W+1)'(tcgr_pkg::TEXT_LINES)) begin
            w_commit_slot = tcgr_pkg::SLOT_W'(sum - (tcgr_pkg::SLOT_W+1)'(tcgr_pkg::TEXT_LINES));
        end else begin
            w_commit_slot = sum[tcgr_pkg::SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_oldest  <= '0;
            r_held    <= '0;
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (i_command)
                            tcgr_pkg::CMD_PUT_CHAR: begin
                                if (!r_stopped) begin
                                    if (i_char_code == '0) begin
                                        r_stopped <= 1'b1;
                                    end else if (32'(r_count) < tcgr_pkg::TEXT_COLUMNS) begin
                                        r_pend[r_count[tcgr_pkg::COL_W-1:0]] <= i_char_code;
                                        r_count <= r_count + 1'b1;
                                    end
                                end
                            end
                            tcgr_pkg::CMD_END_LINE: begin
                                if (w_full) begin
                                    r_oldest <= w_oldest_inc;
                                end else begin
                                    r_held <= r_held + 1'b1;
                                end
                                r_len[w_commit_slot] <= r_count;
                                r_count     <= '0;
                                r_stopped   <= 1'b0;
                                r_copy_slot <= w_commit_slot;
                                r_copy_idx  <= '0;
                                r_copy_last <= tcgr_pkg::COL_W'(r_count - 1'b1);
                                if (r_count != '0) begin
                                    r_state <= ST_COPY;
                                end
                            end
                            tcgr_pkg::CMD_CLEAR: begin
                                r_oldest  <= '0;
                                r_held    <= '0;
                                r_count   <= '0;
                                r_stopped <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_COPY: begin
                    if (r_copy_idx == r_copy_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_copy_idx <= r_copy_idx + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign w_font_we    = w_accept && (i_command == tcgr_pkg::CMD_LOAD_FONT)
                          && (32'(i_glyph_index) < tcgr_pkg::GLYPH_COUNT);
    assign w_font_waddr = tcgr_pkg::FADDR_W'({i_glyph_index, i_glyph_row});

    tcgr_ram #(
        .DEPTH (tcgr_pkg::FONT_DEPTH),
        .WIDTH (tcgr_pkg::BITS_W)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (w_font_we),
        .i_waddr (w_font_waddr),
        .i_wdata (i_glyph_bits),
        .i_raddr (w_font_raddr),
        .o_rdata (w_font_rdata)
    );

    assign w_text_we    = (r_state == ST_COPY);
    assign w_text_waddr = tcgr_pkg::TADDR_W'(r_copy_slot)
                          * tcgr_pkg::TADDR_W'(tcgr_pkg::TEXT_COLUMNS)
                          + tcgr_pkg::TADDR_W'(r_copy_idx);

    tcgr_ram #(
        .DEPTH (tcgr_pkg::TEXT_DEPTH),
        .WIDTH (tcgr_pkg::CODE_W)
    ) u_text (
        .i_clk   (i_clk),
        .i_we    (w_text_we),
        .i_waddr (w_text_waddr),
        .i_wdata (r_pend[r_copy_idx]),
        .i_raddr (w_text_raddr),
        .o_rdata (w_text_rdata)
    );

    assign w_con.oldest  = r_oldest;
    assign w_con.held    = r_held;
    assign w_con.lengths = r_len;

    tcgr_render u_render (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_accept && (i_command == tcgr_pkg::CMD_READ)),
        .i_gate_row   (i_gate_row),
        .i_byte_index (i_byte_index),
        .i_con        (w_con),
        .i_text_rdata (w_text_rdata),
        .i_font_rdata (w_font_rdata),
        .o_text_raddr (w_text_raddr),
        .o_font_raddr (w_font_raddr),
        .o_busy       (w_render_busy),
        .o_valid      (o_valid),
        .o_pixel_byte (o_pixel_byte)
    );

endmodule

`default_nettype wire

FILE: sv/tcgr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcgr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/tcgr_pix_addr.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps one source pixel of the current gate row to a text cell and font row.
module tcgr_pix_addr (
    input  wire logic                          i_col_ok,
    input  wire logic [tcgr_pkg::COL_W-1:0]    i_col,
    input  wire logic [tcgr_pkg::SY_W-1:0]     i_sy,
    input  wire tcgr_pkg::t_console            i_con,
    output tcgr_pkg::t_pix_req                 o_req
);

    always_comb begin
        logic [tcgr_pkg::SY_W-1:0]   dy;
        logic [tcgr_pkg::SY_W-1:0]   line;
        logic [tcgr_pkg::SLOT_W:0]   sum;
        logic [tcgr_pkg::SLOT_W-1:0] slot;
        logic                        in_rng;
        logic                        line_ok;
        logic                        len_ok;

        in_rng  = i_col_ok && (32'(i_sy) < tcgr_pkg::PANEL_SOURCES)
                  && (32'(i_sy) >= tcgr_pkg::MARGIN_SOURCE);
        dy      = i_sy - tcgr_pkg::SY_W'(tcgr_pkg::MARGIN_SOURCE);
        line    = tcgr_pkg::SY_W'(dy / tcgr_pkg::CELL_H);
        line_ok = line < tcgr_pkg::SY_W'(i_con.held);

        // line < held <= TEXT_LINES, so one conditional subtract wraps the slot
        sum  = (tcgr_pkg::SLOT_W+1)'(i_con.oldest)
               + (tcgr_pkg::SLOT_W+1)'(line[tcgr_pkg::SLOT_W-1:0]);
        if (sum >= (tcgr_pkg::SLOT_W+1)'(tcgr_pkg::TEXT_LINES)) begin
            slot = tcgr_pkg::SLOT_W'(sum - (tcgr_pkg::SLOT_W+1)'(tcgr_pkg::TEXT_LINES));
        end else begin
            slot = sum[tcgr_pkg::SLOT_W-1:0];
        end

        len_ok = line_ok && (tcgr_pkg::LEN_W'(i_col) < i_con.lengths[slot]);

        o_req.hit       = in_rng && line_ok && len_ok;
        o_req.row       = tcgr_pkg::FROW_W'((dy % tcgr_pkg::CELL_H) / tcgr_pkg::PIXEL_SCALE);
        o_req.text_addr = tcgr_pkg::TADDR_W'(slot) * tcgr_pkg::TADDR_W'(tcgr_pkg::TEXT_COLUMNS)
                          + tcgr_pkg::TADDR_W'(i_col);
    end

endmodule

`default_nettype wire

FILE: sv/tcgr_render.sv
`timescale 1ns / 1ps
`default_nettype none

// Walks the eight pixels of one byte through a three-step lookup:
// address unit -> text memory -> font memory, one pixel entering per cycle.
module tcgr_render (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [tcgr_pkg::GATE_W-1:0]    i_gate_row,
    input  wire logic [tcgr_pkg::BIDX_W-1:0]    i_byte_index,
    input  wire tcgr_pkg::t_console             i_con,
    input  wire logic [tcgr_pkg::CODE_W-1:0]    i_text_rdata,
    input  wire logic [tcgr_pkg::BITS_W-1:0]    i_font_rdata,
    output logic      [tcgr_pkg::TADDR_W-1:0]   o_text_raddr,
    output logic      [tcgr_pkg::FADDR_W-1:0]   o_font_raddr,
    output logic                                o_busy,
    output logic                                o_valid,
    output logic      [tcgr_pkg::PIX_W-1:0]     o_pixel_byte
);

    logic                              r_run;
    logic [tcgr_pkg::STEP_W-1:0]       r_step;
    logic                              r_col_ok;
    logic [tcgr_pkg::COL_W-1:0]        r_col;
    logic [tcgr_pkg::BITS_W-1:0]       r_mask;
    logic [tcgr_pkg::SY_W-1:0]         r_sy_base;
    logic                              r_b_vld;
    logic                              r_b_hit;
    logic [tcgr_pkg::FROW_W-1:0]       r_b_row;
    logic [tcgr_pkg::PIX_IDX_W-1:0]    r_b_idx;
    logic                              r_c_vld;
    logic                              r_c_hit;
    logic [tcgr_pkg::PIX_IDX_W-1:0]    r_c_idx;
    logic [tcgr_pkg::PIX_W-1:0]        r_value;
    logic [tcgr_pkg::PIX_W-1:0]        n_value;

    logic                              w_col_ok;
    logic [tcgr_pkg::COL_W-1:0]        w_col;
    logic [tcgr_pkg::BITS_W-1:0]       w_mask;
    logic                              w_a_vld;
    logic [tcgr_pkg::SY_W-1:0]         w_sy;
    tcgr_pkg::t_pix_req                w_req;
    logic                              w_b_hit;
    logic                              w_c_last;

    // Column and font bit are fixed by the gate row for the whole byte
    always_comb begin
        logic [tcgr_pkg::GATE_W-1:0] dx;
        logic [tcgr_pkg::GATE_W-1:0] col_full;
        logic                        gate_ok;

        gate_ok  = (32'(i_gate_row) >= tcgr_pkg::MARGIN_GATE)
                   && (32'(i_gate_row) < tcgr_pkg::PANEL_GATES);
        dx       = i_gate_row - tcgr_pkg::GATE_W'(tcgr_pkg::MARGIN_GATE);
        col_full = tcgr_pkg::GATE_W'(dx / tcgr_pkg::CELL_W);
        w_col_ok = gate_ok && (32'(col_full) < tcgr_pkg::TEXT_COLUMNS);
        w_col    = col_full[tcgr_pkg::COL_W-1:0];
        w_mask   = tcgr_pkg::BITS_W'(8'h80 >> ((dx % tcgr_pkg::CELL_W) / tcgr_pkg::PIXEL_SCALE));
    end

    assign w_a_vld = r_run && !r_step[tcgr_pkg::STEP_W-1];
    assign w_sy    = r_sy_base + tcgr_pkg::SY_W'(r_step[tcgr_pkg::PIX_IDX_W-1:0]);

    tcgr_pix_addr u_addr (
        .i_col_ok (r_col_ok),
        .i_col    (r_col),
        .i_sy     (w_sy),
        .i_con    (i_con),
        .o_req    (w_req)
    );

    assign o_text_raddr = w_req.text_addr;

    // Code from text memory -> glyph, with '?' for codes outside the set
    always_comb begin
        logic [tcgr_pkg::GLYPH_IDX_W-1:0] glyph;
        logic                             code_ok;

        if (i_text_rdata inside {[tcgr_pkg::FIRST_CODE:tcgr_pkg::LAST_CODE]}) begin
            glyph   = tcgr_pkg::GLYPH_IDX_W'(i_text_rdata - tcgr_pkg::CODE_W'(tcgr_pkg::FIRST_CODE));
            code_ok = 1'b1;
        end else begin
            glyph   = tcgr_pkg::GLYPH_IDX_W'(tcgr_pkg::FALLBACK_CODE - tcgr_pkg::FIRST_CODE);
            code_ok = tcgr_pkg::FALLBACK_OK;
        end
        w_b_hit      = r_b_hit && code_ok;
        o_font_raddr = tcgr_pkg::FADDR_W'({glyph, r_b_row});
    end

    always_comb begin
        n_value = r_value;
        if (r_c_vld && r_c_hit && ((i_font_rdata & r_mask) != '0)) begin
            n_value = r_value & ~(tcgr_pkg::PIX_W'(8'h80) >> r_c_idx);
        end
    end

    assign w_c_last = r_c_vld && (r_c_idx == tcgr_pkg::PIX_IDX_W'(tcgr_pkg::PIX_W - 1));
    assign o_busy   = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_step  <= '0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_b_vld <= w_a_vld;
            r_c_vld <= r_b_vld;
            if (i_start) begin
                r_run     <= 1'b1;
                r_step    <= '0;
                r_col_ok  <= w_col_ok;
                r_col     <= w_col;
                r_mask    <= w_mask;
                r_sy_base <= {i_byte_index, {tcgr_pkg::PIX_IDX_W{1'b0}}};
                r_value   <= '1;
            end else if (r_run) begin
                if (w_a_vld) begin
                    r_step <= r_step + 1'b1;
                end
                r_value <= n_value;
                if (w_c_last) begin
                    r_run        <= 1'b0;
                    o_valid      <= 1'b1;
                    o_pixel_byte <= n_value;
                end
            end
            r_b_hit <= w_req.hit;
            r_b_row <= w_req.row;
            r_b_idx <= r_step[tcgr_pkg::PIX_IDX_W-1:0];
            r_c_hit <= w_b_hit;
            r_c_idx <= r_b_idx;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tcgr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tcgr_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic [tcgr_pkg::CMD_W-1:0] i_command,
    input wire logic                       o_valid
);

    // A read transfer occupies the block until its byte comes out
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == tcgr_pkg::CMD_READ) |=> busy)
        else $error("read transfer did not raise busy");

    // Every result closes a busy period
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a preceding read");

    // One byte per read
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // Font loads, puts, clears and unknown codes finish at the transfer
    a_quick_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command != tcgr_pkg::CMD_READ
         && i_command != tcgr_pkg::CMD_END_LINE) |=> (!busy && !o_valid))
        else $error("non-read command held the block or produced a result");

endmodule

bind text_console_glyph_renderer_unit tcgr_checker u_tcgr_checker (.*);

`default_nettype wire
